// ----- src/ntl_pkg.sv -----
package ntl_pkg;

   localparam int StampWidth = 64;
   localparam int IndexWidth = 10;
   localparam int CountWidth = 11;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // query modes
   localparam logic [1:0] MODE_CLOSEST = 2'd0;
   localparam logic [1:0] MODE_BEFORE  = 2'd1;
   localparam logic [1:0] MODE_AFTER   = 2'd2;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   // result status
   localparam logic [1:0] STATUS_FOUND   = 2'd0;
   localparam logic [1:0] STATUS_NONE    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef logic [2:0] slot_type;

   // entries fetched after the search, in issue order
   localparam slot_type SLOT_FIRST  = 3'd0;
   localparam slot_type SLOT_LAST   = 3'd1;
   localparam slot_type SLOT_LOWER  = 3'd2;
   localparam slot_type SLOT_AFTER  = 3'd3;
   localparam slot_type SLOT_BEFORE = 3'd4;

   typedef struct packed {
      logic     load_wr;
      logic     start;
      logic     search;
      logic     fetch_en;
      slot_type fetch_slot;
      logic     compare;
      logic     out_load;
   } ntl_cmd_type;

   typedef struct packed {
      logic search_done;
      logic out_free;
   } ntl_sts_type;

endpackage

// ----- src/ntl_ram.sv -----
module ntl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- src/ntl_ctrl.sv -----
module ntl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_type,
   output logic                 req_stall,
   output ntl_pkg::ntl_cmd_type cmd,
   input  ntl_pkg::ntl_sts_type sts
);

   import ntl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_LAND   = 3'd3;
   localparam logic [2:0] ST_DIST   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   slot_type   fetch_slot_ff;
   slot_type   fetch_slot_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      fetch_slot_in = fetch_slot_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.search_done) begin
               state_in      = ST_FETCH;
               fetch_slot_in = SLOT_FIRST;
            end
         end
         ST_FETCH: begin
            cmd.fetch_en   = 1'b1;
            cmd.fetch_slot = fetch_slot_ff;
            if (fetch_slot_ff == SLOT_BEFORE) begin
               state_in = ST_LAND;
            end else begin
               fetch_slot_in = fetch_slot_ff + 3'd1;
            end
         end
         // last fetched entry lands in its register
         ST_LAND: begin
            state_in = ST_DIST;
         end
         ST_DIST: begin
            cmd.compare = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fetch_slot_ff <= SLOT_FIRST;
      end else begin
         state_ff      <= state_in;
         fetch_slot_ff <= fetch_slot_in;
      end
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded while output register busy");

   a_search_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && sts.search_done) |=> state_ff == ST_FETCH)
      else $error("search finished without moving to fetch");

   a_fetch_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && fetch_slot_ff == SLOT_BEFORE) |=> state_ff == ST_LAND)
      else $error("fetch sequence did not end after last slot");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_SEARCH && !cmd.out_load))
      else $error("query accepted without entering search");

endmodule

// ----- src/ntl_dp.sv -----
module ntl_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ntl_pkg::ntl_cmd_type        cmd,
   output ntl_pkg::ntl_sts_type        sts,
   input  logic [9:0]                  req_load_index,
   input  logic signed [63:0]          req_stamp,
   input  logic [1:0]                  req_query_mode,
   input  logic                        csr_wr_en,
   input  logic [10:0]                 csr_entry_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [9:0]                  rsp_result_index,
   output logic signed [63:0]          rsp_result_stamp
);

   import ntl_pkg::*;

   localparam int IW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > CountWidth) ? CW : CountWidth;
   localparam int LW   = (CW > IndexWidth) ? CW : IndexWidth;
   localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(TABLE_DEPTH);
   localparam logic [LW-1:0]   DEPTH_LW  = LW'(TABLE_DEPTH);

   function automatic logic [63:0] magnitude(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
      logic [63:0] d;
      if (a >= b) begin
         d = a - b;
      end else begin
         d = b - a;
      end
      return d;
   endfunction

   logic [10:0]        entry_count_ff;
   logic [CW-1:0]      n_c;
   logic [CW-1:0]      n_m1_c;

   logic signed [63:0] query_ff;
   logic [1:0]         mode_ff;
   logic [CW-1:0]      lo_ff;
   logic [CW-1:0]      hi_ff;
   logic [CW-1:0]      mid_ff;
   logic               pend_ff;
   logic [CW-1:0]      lo_c;
   logic [CW-1:0]      hi_c;
   logic [CW:0]        sum_c;
   logic [CW-1:0]      mid_c;

   logic [CW-1:0]      after_c;
   logic [CW-1:0]      before_c;
   logic [IW-1:0]      slot_addr_c;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [IW-1:0]      ram_rd_addr;
   logic [63:0]        ram_rd_data;
   logic signed [63:0] rd_stamp;

   logic               cap_en_ff;
   slot_type           cap_slot_ff;
   logic signed [63:0] e_first_ff;
   logic signed [63:0] e_last_ff;
   logic signed [63:0] e_lower_ff;
   logic signed [63:0] e_after_ff;
   logic signed [63:0] e_before_ff;

   logic               exact_ff;
   logic               below_ff;
   logic               above_ff;
   logic [63:0]        dist_before_ff;
   logic [63:0]        dist_after_ff;

   logic [1:0]         sel_status_c;
   logic [CW-1:0]      sel_index_c;
   logic signed [63:0] sel_stamp_c;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [9:0]         rsp_index_ff;
   logic signed [63:0] rsp_stamp_ff;

   // active entry count, clamped to 1 .. depth
   always_comb begin
      if (entry_count_ff == '0) begin
         n_c = CW'(1);
      end else if (CMPW'(entry_count_ff) > DEPTH_CMP) begin
         n_c = CW'(TABLE_DEPTH);
      end else begin
         n_c = CW'(entry_count_ff);
      end
      n_m1_c = n_c - CW'(1);
   end

   assign rd_stamp = ram_rd_data;

   // one search step per cycle: last read decides, next address issues at once
   always_comb begin
      lo_c = lo_ff;
      hi_c = hi_ff;
      if (pend_ff) begin
         if (rd_stamp < query_ff) begin
            lo_c = mid_ff + CW'(1);
         end else begin
            hi_c = mid_ff;
         end
      end
      sum_c = {1'b0, lo_c} + {1'b0, hi_c};
      mid_c = sum_c[CW:1];
      sts.search_done = !(lo_c < hi_c);
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // neighbors of the lower bound for the interior case
   always_comb begin
      after_c = lo_ff;
      if (after_c > n_m1_c) begin
         after_c = n_m1_c;
      end
      if (after_c < CW'(1)) begin
         after_c = CW'(1);
      end
      if (after_c >= n_c) begin
         after_c = '0;
      end
      before_c = (after_c != '0) ? after_c - CW'(1) : '0;
   end

   always_comb begin
      unique case (cmd.fetch_slot)
         SLOT_FIRST:  slot_addr_c = '0;
         SLOT_LAST:   slot_addr_c = n_m1_c[IW-1:0];
         SLOT_LOWER:  slot_addr_c = lo_ff[IW-1:0];
         SLOT_AFTER:  slot_addr_c = after_c[IW-1:0];
         SLOT_BEFORE: slot_addr_c = before_c[IW-1:0];
         default:     slot_addr_c = '0;
      endcase
   end

   assign ram_wr_en   = cmd.load_wr && (LW'(req_load_index) < DEPTH_LW);
   assign ram_rd_en   = (cmd.search && !sts.search_done) || cmd.fetch_en;
   assign ram_rd_addr = cmd.fetch_en ? slot_addr_c : mid_c[IW-1:0];

   ntl_ram #(
      .WIDTH(StampWidth),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(IW'(req_load_index)),
      .wr_data(req_stamp),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      sel_status_c = STATUS_FOUND;
      sel_index_c  = '0;
      sel_stamp_c  = '0;
      priority if (exact_ff) begin
         sel_index_c = lo_ff;
         sel_stamp_c = e_lower_ff;
      end else if (below_ff) begin
         if (mode_ff == MODE_BEFORE) begin
            sel_status_c = STATUS_NONE;
         end else begin
            sel_stamp_c = e_first_ff;
         end
      end else if (above_ff) begin
         if (mode_ff == MODE_AFTER) begin
            sel_status_c = STATUS_NONE;
         end else begin
            sel_index_c = n_m1_c;
            sel_stamp_c = e_last_ff;
         end
      end else begin
         unique case (mode_ff)
            MODE_CLOSEST: begin
               // tie goes to the later entry
               if (dist_before_ff < dist_after_ff) begin
                  sel_index_c = before_c;
                  sel_stamp_c = e_before_ff;
               end else begin
                  sel_index_c = after_c;
                  sel_stamp_c = e_after_ff;
               end
            end
            MODE_BEFORE: begin
               sel_index_c = before_c;
               sel_stamp_c = e_before_ff;
            end
            MODE_AFTER: begin
               sel_index_c = after_c;
               sel_stamp_c = e_after_ff;
            end
            default: begin
               sel_status_c = STATUS_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 11'd1;
         pend_ff        <= 1'b0;
         cap_en_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            entry_count_ff <= csr_entry_count;
         end
         if (cmd.start) begin
            pend_ff <= 1'b0;
         end else if (cmd.search) begin
            pend_ff <= !sts.search_done;
         end
         cap_en_ff <= cmd.fetch_en;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         query_ff <= req_stamp;
         mode_ff  <= req_query_mode;
         lo_ff    <= '0;
         hi_ff    <= n_c;
      end else if (cmd.search) begin
         lo_ff  <= lo_c;
         hi_ff  <= hi_c;
         mid_ff <= mid_c;
      end
      cap_slot_ff <= cmd.fetch_slot;
      if (cap_en_ff) begin
         unique case (cap_slot_ff)
            SLOT_FIRST:  e_first_ff  <= rd_stamp;
            SLOT_LAST:   e_last_ff   <= rd_stamp;
            SLOT_LOWER:  e_lower_ff  <= rd_stamp;
            SLOT_AFTER:  e_after_ff  <= rd_stamp;
            SLOT_BEFORE: e_before_ff <= rd_stamp;
            default: begin
            end
         endcase
      end
      if (cmd.compare) begin
         exact_ff       <= (lo_ff < n_c) && (e_lower_ff == query_ff);
         below_ff       <= query_ff < e_first_ff;
         above_ff       <= query_ff > e_last_ff;
         dist_before_ff <= magnitude(e_before_ff, query_ff);
         dist_after_ff  <= magnitude(e_after_ff, query_ff);
      end
      if (cmd.out_load) begin
         rsp_status_ff <= sel_status_c;
         rsp_index_ff  <= IndexWidth'(sel_index_c);
         rsp_stamp_ff  <= sel_stamp_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_stamp = rsp_stamp_ff;

endmodule

// ----- src/nearest_timestamp_lookup_core.sv -----
// Nearest-timestamp lookup over a table of signed 64-bit timestamps held in a
// single-port-read block RAM. A load beat writes one entry in the cycle it is
// accepted and gives no response; loads can follow each other every cycle
// while no query is in progress. A query beat runs a binary search over the
// first csr_entry_count entries, clamped to 1 .. TABLE_DEPTH (one RAM read
// per cycle, the compare of each read steering the next address), then
// fetches the first, last, lower-bound and two neighboring entries (five
// reads), lets the last read land in its register, compares the query with
// the fetched entries and selects the result. A query keeps req_stall high
// until its result is loaded into the output register, and longer while the
// previous response is still held there. The response sits in an output
// register, so the next request is taken while it waits. Entries that were
// never loaded read as unknown, so the table must be loaded in ascending
// order before it is queried.
module nearest_timestamp_lookup_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [9:0]         req_load_index,
   input  logic signed [63:0] req_stamp,
   input  logic [1:0]         req_query_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [9:0]         rsp_result_index,
   output logic signed [63:0] rsp_result_stamp,
   input  logic               csr_wr_en,
   input  logic [10:0]        csr_entry_count
);

   import ntl_pkg::*;

   ntl_cmd_type cmd;
   ntl_sts_type sts;

   ntl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_type (req_type),
      .req_stall(req_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   ntl_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_load_index  (req_load_index),
      .req_stamp       (req_stamp),
      .req_query_mode  (req_query_mode),
      .csr_wr_en       (csr_wr_en),
      .csr_entry_count (csr_entry_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_index(rsp_result_index),
      .rsp_result_stamp(rsp_result_stamp)
   );

endmodule

// ----- tb/sv/tb_nearest_timestamp_lookup_core.sv -----
`timescale 1ns / 1ps

module tb_nearest_timestamp_lookup_core;
   import ntl_pkg::*;

   localparam int DEPTH = 1024;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE = 40;
   localparam logic signed [63:0] STAMP_MIN = {1'b1, 63'd0};
   localparam logic signed [63:0] STAMP_MAX = {1'b0, {63{1'b1}}};

   typedef struct packed {
      logic [1:0]            status;
      logic [IndexWidth-1:0] index;
      logic [StampWidth-1:0] stamp;
   } lookup_result_type;

   class lookup_tracker;
      logic signed [63:0] stamps[DEPTH];
      int count = 1;
      lookup_result_type expected_hits[$];
      int errors = 0;

      function void set_count(int value);
         count = value;
      endfunction

      // exact magnitude of a - b at 65 bits
      function logic [64:0] gap(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] d;
         d = $signed({a[63], a}) - $signed({b[63], b});
         if (d < 0) d = -d;
         return d;
      endfunction

      function void push(logic [1:0] st, int idx, logic hit);
         lookup_result_type r;
         r.status = st;
         r.index = hit ? idx[IndexWidth-1:0] : '0;
         r.stamp = hit ? stamps[idx] : '0;
         expected_hits.push_back(r);
      endfunction

      function void note_request(logic typ, logic [9:0] idx, logic signed [63:0] st,
                                 logic [1:0] mode);
         int n, lo, hi, mid, aft, bef;
         if (typ == REQ_LOAD) begin
            stamps[idx] = st;
            return;
         end
         n = (count == 0) ? 1 : (count > DEPTH) ? DEPTH : count;
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (stamps[mid] < st) lo = mid + 1;
            else hi = mid;
         end
         if (lo < n && stamps[lo] == st) begin
            push(STATUS_FOUND, lo, 1'b1);
         end else if (st < stamps[0]) begin
            if (mode == MODE_BEFORE) push(STATUS_NONE, 0, 1'b0);
            else push(STATUS_FOUND, 0, 1'b1);
         end else if (st > stamps[n-1]) begin
            if (mode == MODE_AFTER) push(STATUS_NONE, 0, 1'b0);
            else push(STATUS_FOUND, n - 1, 1'b1);
         end else begin
            // interior: clamp the lower bound so both neighbors exist
            aft = lo;
            if (aft > n - 1) aft = n - 1;
            if (aft < 1) aft = 1;
            if (aft >= n) aft = 0;
            bef = (aft > 0) ? aft - 1 : 0;
            case (mode)
               MODE_CLOSEST: begin
                  if (gap(stamps[bef], st) < gap(stamps[aft], st)) push(STATUS_FOUND, bef, 1'b1);
                  else push(STATUS_FOUND, aft, 1'b1);
               end
               MODE_BEFORE: push(STATUS_FOUND, bef, 1'b1);
               MODE_AFTER:  push(STATUS_FOUND, aft, 1'b1);
               default:     push(STATUS_INVALID, 0, 1'b0);
            endcase
         end
      endfunction

      function void check_response(logic [1:0] st, logic [9:0] idx, logic [63:0] value);
         lookup_result_type want;
         if (expected_hits.size() == 0) begin
            $error("unexpected response: status %0d index %0d stamp %0d",
                   st, idx, $signed(value));
            errors++;
            return;
         end
         want = expected_hits.pop_front();
         if (st !== want.status) begin
            $error("status expected %0d got %0d", want.status, st);
            errors++;
         end
         if (idx !== want.index) begin
            $error("result_index expected %0d got %0d", want.index, idx);
            errors++;
         end
         if (value !== want.stamp) begin
            $error("result_stamp expected %0d got %0d", $signed(want.stamp), $signed(value));
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = REQ_LOAD;
   logic [9:0]         req_load_index = '0;
   logic signed [63:0] req_stamp = '0;
   logic [1:0]         req_query_mode = MODE_CLOSEST;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [9:0]         rsp_result_index;
   logic signed [63:0] rsp_result_stamp;
   logic               csr_wr_en = 1'b0;
   logic [10:0]        csr_entry_count = 11'd1;

   logic calm = 1'b0;
   int cycles = 0;
   logic signed [63:0] loaded[DEPTH];
   int phase_counts[11] = '{1, 0, 2, 2, 3, 5, 16, 37, 100, 7, 9};
   lookup_tracker tracker = new();

   nearest_timestamp_lookup_core #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_load_index   (req_load_index),
      .req_stamp        (req_stamp),
      .req_query_mode   (req_query_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_result_stamp (rsp_result_stamp),
      .csr_wr_en        (csr_wr_en),
      .csr_entry_count  (csr_entry_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("nearest_timestamp_lookup_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 22);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_request(req_type, req_load_index, req_stamp, req_query_mode);
         if (rsp_valid && !rsp_stall)
            tracker.check_response(rsp_status, rsp_result_index, rsp_result_stamp);
      end
   end

   task automatic send_beat(logic typ, logic [9:0] idx, logic signed [63:0] value,
                            logic [1:0] mode);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_load_index <= idx;
      req_stamp <= value;
      req_query_mode <= mode;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic load_entry(int idx, logic signed [63:0] value);
      loaded[idx] = value;
      send_beat(REQ_LOAD, idx[9:0], value, 2'($urandom_range(3)));
   endtask

   task automatic ask(logic signed [63:0] value, logic [1:0] mode);
      send_beat(REQ_QUERY, 10'($urandom_range(DEPTH - 1)), value, mode);
   endtask

   // wait until every query beat has its response, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_hits.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_entry_count(int value);
      settle();
      csr_wr_en <= 1'b1;
      csr_entry_count <= value[10:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_count(value);
   endtask

   task automatic fill_table(int n, bit extremes);
      logic signed [63:0] v;
      logic signed [63:0] step;
      if ($urandom_range(1)) v = $signed({$urandom, $urandom}) >>> 2;
      else v = $signed(64'($urandom_range(2000))) - 64'sd1000;
      for (int i = 0; i < n; i++) begin
         if (extremes && i == 0) load_entry(i, STAMP_MIN);
         else if (extremes && i == n - 1) load_entry(i, STAMP_MAX);
         else load_entry(i, v);
         case ($urandom_range(3))
            0:       step = 64'sd1;
            1:       step = 64'(2 * $urandom_range(1, 8));
            2:       step = 64'($urandom_range(1, 1000));
            default: step = (64'($urandom) << $urandom_range(0, 8)) + 64'd1;
         endcase
         v = v + step;
      end
   endtask

   function automatic logic signed [63:0] pick_stamp(int n);
      int k;
      logic signed [64:0] sum;
      k = $urandom_range(n - 1);
      case ($urandom_range(9))
         0:       return $signed({$urandom, $urandom});
         1:       return STAMP_MIN;
         2:       return STAMP_MAX;
         3, 4, 5: return loaded[k];
         6, 7:    return loaded[k] + $signed(64'($urandom_range(6))) - 64'sd3;
         default: begin
            if (k == n - 1) return loaded[k] + 64'sd1;
            // midpoint of two neighbors, a closest-mode tie when the gap is even
            sum = $signed({loaded[k][63], loaded[k]}) + $signed({loaded[k+1][63], loaded[k+1]});
            return sum[64:1];
         end
      endcase
   endfunction

   initial begin
      int eff, prev_eff, hits, r, spot;
      logic signed [63:0] value;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // small table with an even gap in the middle
      set_entry_count(4);
      load_entry(0, -100);
      load_entry(1, -5);
      load_entry(2, 11);
      load_entry(3, 1000);
      load_entry(1023, STAMP_MAX);
      ask(-5, MODE_CLOSEST);
      ask(11, MODE_INVALID);
      ask(STAMP_MIN, MODE_BEFORE);
      ask(STAMP_MIN, MODE_CLOSEST);
      ask(STAMP_MIN, MODE_INVALID);
      ask(STAMP_MAX, MODE_AFTER);
      ask(STAMP_MAX, MODE_BEFORE);
      ask(STAMP_MAX, MODE_INVALID);
      ask(3, MODE_CLOSEST);
      ask(0, MODE_CLOSEST);
      ask(3, MODE_BEFORE);
      ask(3, MODE_AFTER);
      ask(3, MODE_INVALID);
      ask(-100, MODE_AFTER);
      ask(1000, MODE_BEFORE);
      prev_eff = 4;

      foreach (phase_counts[p]) begin
         eff = (phase_counts[p] == 0) ? 1 : (phase_counts[p] > DEPTH) ? DEPTH : phase_counts[p];
         set_entry_count(phase_counts[p]);
         calm <= (p == 6);
         if (!(eff == DEPTH && prev_eff == DEPTH))
            fill_table(eff, p == 3 || $urandom_range(4) == 0);
         hits = 0;
         while (hits < 24) begin
            r = $urandom_range(99);
            if (r < 8) begin
               // nudge one entry by one while keeping the order
               spot = $urandom_range(eff - 1);
               value = loaded[spot];
               if ($urandom_range(1)) begin
                  if (spot == 0 ? value != STAMP_MIN : value - 1 > loaded[spot - 1])
                     value = value - 1;
               end else begin
                  if (spot == eff - 1 ? value != STAMP_MAX : value + 1 < loaded[spot + 1])
                     value = value + 1;
               end
               load_entry(spot, value);
            end else if (r < 11) begin
               if (eff < DEPTH) load_entry($urandom_range(DEPTH - 1, eff), {$urandom, $urandom});
            end else if (r == 11) begin
               load_entry($urandom_range(eff - 1), {$urandom, $urandom});
            end else begin
               ask(pick_stamp(eff), 2'($urandom_range(3)));
               hits++;
            end
         end
         prev_eff = eff;
      end
      calm <= 1'b0;
      settle();

      if (tracker.errors == 0 && tracker.expected_hits.size() == 0) begin
         $display("nearest_timestamp_lookup_core verification clean");
      end else begin
         $display("nearest_timestamp_lookup_core verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/ntl_pkg.sv
src/ntl_ram.sv
src/ntl_ctrl.sv
src/ntl_dp.sv
src/nearest_timestamp_lookup_core.sv
tb/sv/tb_nearest_timestamp_lookup_core.sv
